FILE: rtl/core/bft_pkg.sv
// ----------------------------------------------------------------------------
// bft_pkg
// Shared types, constants and helpers for the boundary face table.
// ----------------------------------------------------------------------------
package bft_pkg;

  localparam int TableDepth = 1024;
  localparam int VertexBits = 16;

  localparam int IdxBits   = $clog2(TableDepth);
  localparam int CountBits = $clog2(TableDepth + 1);

  // fixed field widths of the transaction payloads
  localparam int ActionW = 2;
  localparam int VertexW = 16;
  localparam int SlotW   = 10;
  localparam int HeldW   = 11;

  localparam logic [ActionW-1:0] ActInsert = 2'd0;
  localparam logic [ActionW-1:0] ActRead   = 2'd1;
  localparam logic [ActionW-1:0] ActClear  = 2'd2;

  typedef logic [VertexBits-1:0] vtx_t;

  typedef struct packed {
    vtx_t a;
    vtx_t b;
    vtx_t c;
  } face_t;

  // canonical key, descending order
  typedef struct packed {
    vtx_t k0;
    vtx_t k1;
    vtx_t k2;
  } key_t;

  typedef struct packed {
    logic  shared;
    key_t  key;
    face_t orig;
  } entry_t;

  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [VertexW-1:0] vertex_a;
    logic [VertexW-1:0] vertex_b;
    logic [VertexW-1:0] vertex_c;
    logic [SlotW-1:0]   read_slot;
  } item_t;

  typedef struct packed {
    logic [SlotW-1:0]   slot_out;
    logic               was_new;
    logic               table_full;
    logic [VertexW-1:0] face_vertex_a;
    logic [VertexW-1:0] face_vertex_b;
    logic [VertexW-1:0] face_vertex_c;
    logic               is_boundary;
    logic               slot_valid;
    logic [HeldW-1:0]   faces_held;
  } result_t;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StRead
  } state_e;

  // three compare-exchange steps
  function automatic key_t sort_desc(face_t f);
    vtx_t x0;
    vtx_t x1;
    vtx_t x2;
    vtx_t t;
    key_t k;
    x0 = f.a;
    x1 = f.b;
    x2 = f.c;
    if (x0 < x1) begin
      t = x0; x0 = x1; x1 = t;
    end
    if (x1 < x2) begin
      t = x1; x1 = x2; x2 = t;
    end
    if (x0 < x1) begin
      t = x0; x0 = x1; x1 = t;
    end
    k.k0 = x0;
    k.k1 = x1;
    k.k2 = x2;
    return k;
  endfunction

endpackage

FILE: rtl/core/bft_ram.sv
// ----------------------------------------------------------------------------
// bft_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bft_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/core/boundary_face_table.sv
// ----------------------------------------------------------------------------
// boundary_face_table
// Face table for boundary extraction of a tetrahedral mesh.
// ----------------------------------------------------------------------------
// A transaction is taken on item_i at a rising edge with start high and busy
// low. Exactly one result follows on result_o, shown for one cycle with
// strobe high; the receiver cannot hold it off.
// Insert: the sorted key is compared against the held entries one per cycle
// through the table RAM, in slot order, and the scan stops at the first match;
// an empty table takes the face straight from idle. A match writes the shared
// mark back, a miss appends at the fill count, or sets table_full if the
// table already holds TableDepth faces.
// Read of a held entry goes through the registered RAM read. A read past the
// fill count, clear and the unused action are answered from idle.
// busy is high from the accepting edge until the edge that raises strobe, so
// a new transaction may be taken in the cycle the result is shown.
// Reset empties the table by clearing the fill count; the RAM is not swept,
// entries at or above the count are never looked at.
// ----------------------------------------------------------------------------
module boundary_face_table (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  bft_pkg::item_t   item_i,
  output logic             strobe,
  output bft_pkg::result_t result_o
);

  bft_pkg::state_e state_q, state_d;
  logic [bft_pkg::CountBits-1:0] count_q, count_d;
  logic [bft_pkg::IdxBits-1:0]   idx_q, idx_d;
  logic                          strobe_q, strobe_d;
  bft_pkg::key_t                 key_q, key_d;
  bft_pkg::face_t                orig_q, orig_d;
  bft_pkg::result_t              res_q, res_d;

  logic                          ram_we;
  logic [bft_pkg::IdxBits-1:0]   ram_waddr;
  bft_pkg::entry_t               ram_wdata;
  logic [bft_pkg::IdxBits-1:0]   ram_raddr;
  bft_pkg::entry_t               ram_rdata;

  bft_pkg::face_t                in_face;
  bft_pkg::key_t                 in_key;
  logic                          hit;
  logic                          last;
  logic [bft_pkg::CountBits-1:0] slot_ext;

  assign in_face.a = item_i.vertex_a[bft_pkg::VertexBits-1:0];
  assign in_face.b = item_i.vertex_b[bft_pkg::VertexBits-1:0];
  assign in_face.c = item_i.vertex_c[bft_pkg::VertexBits-1:0];
  assign in_key    = bft_pkg::sort_desc(in_face);
  assign slot_ext  = bft_pkg::CountBits'(item_i.read_slot);
  assign hit       = (ram_rdata.key == key_q);
  assign last      = ((bft_pkg::CountBits'(idx_q) + bft_pkg::CountBits'(1)) == count_q);

  bft_ram #(
    .Width($bits(bft_pkg::entry_t)),
    .Depth(bft_pkg::TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    key_d     = key_q;
    orig_d    = orig_q;
    strobe_d  = 1'b0;
    res_d     = '0;
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = '0;
    ram_raddr = '0;
    case (state_q)
      bft_pkg::StIdle: begin
        if (start) begin
          case (item_i.action)
            bft_pkg::ActInsert: begin
              key_d  = in_key;
              orig_d = in_face;
              if (count_q == '0) begin
                ram_we           = 1'b1;
                ram_waddr        = '0;
                ram_wdata.shared = 1'b0;
                ram_wdata.key    = in_key;
                ram_wdata.orig   = in_face;
                count_d          = bft_pkg::CountBits'(1);
                res_d.was_new    = 1'b1;
                res_d.slot_valid = 1'b1;
                strobe_d         = 1'b1;
              end else begin
                idx_d     = '0;
                ram_raddr = '0;
                state_d   = bft_pkg::StScan;
              end
            end
            bft_pkg::ActRead: begin
              if (slot_ext < count_q) begin
                idx_d     = bft_pkg::IdxBits'(item_i.read_slot);
                ram_raddr = bft_pkg::IdxBits'(item_i.read_slot);
                state_d   = bft_pkg::StRead;
              end else begin
                res_d.slot_out = item_i.read_slot;
                strobe_d       = 1'b1;
              end
            end
            bft_pkg::ActClear: begin
              count_d  = '0;
              strobe_d = 1'b1;
            end
            default: begin
              strobe_d = 1'b1;
            end
          endcase
        end
      end
      bft_pkg::StScan: begin
        if (hit) begin
          ram_we           = 1'b1;
          ram_waddr        = idx_q;
          ram_wdata        = ram_rdata;
          ram_wdata.shared = 1'b1;
          res_d.slot_out   = bft_pkg::SlotW'(idx_q);
          res_d.slot_valid = 1'b1;
          strobe_d         = 1'b1;
          state_d          = bft_pkg::StIdle;
        end else if (last) begin
          if (count_q == bft_pkg::CountBits'(bft_pkg::TableDepth)) begin
            res_d.table_full = 1'b1;
          end else begin
            ram_we           = 1'b1;
            ram_waddr        = count_q[bft_pkg::IdxBits-1:0];
            ram_wdata.shared = 1'b0;
            ram_wdata.key    = key_q;
            ram_wdata.orig   = orig_q;
            count_d          = count_q + bft_pkg::CountBits'(1);
            res_d.slot_out   = bft_pkg::SlotW'(count_q[bft_pkg::IdxBits-1:0]);
            res_d.was_new    = 1'b1;
            res_d.slot_valid = 1'b1;
          end
          strobe_d = 1'b1;
          state_d  = bft_pkg::StIdle;
        end else begin
          idx_d     = idx_q + bft_pkg::IdxBits'(1);
          ram_raddr = idx_q + bft_pkg::IdxBits'(1);
        end
      end
      bft_pkg::StRead: begin
        res_d.slot_out      = bft_pkg::SlotW'(idx_q);
        res_d.face_vertex_a = bft_pkg::VertexW'(ram_rdata.orig.a);
        res_d.face_vertex_b = bft_pkg::VertexW'(ram_rdata.orig.b);
        res_d.face_vertex_c = bft_pkg::VertexW'(ram_rdata.orig.c);
        res_d.is_boundary   = ~ram_rdata.shared;
        res_d.slot_valid    = 1'b1;
        strobe_d            = 1'b1;
        state_d             = bft_pkg::StIdle;
      end
      default: begin
        state_d = bft_pkg::StIdle;
      end
    endcase
    res_d.faces_held = bft_pkg::HeldW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= bft_pkg::StIdle;
      count_q  <= '0;
      idx_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    orig_q <= orig_d;
    res_q  <= res_d;
  end

  assign busy     = (state_q != bft_pkg::StIdle);
  assign strobe   = strobe_q;
  assign result_o = res_q;

`ifndef NO_ASSERTIONS
  a_strobe_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe |-> !busy)
    else $error("result strobed while a transaction is still in flight");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= bft_pkg::CountBits'(bft_pkg::TableDepth))
    else $error("fill count beyond table depth");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (strobe || busy))
    else $error("accepted transaction neither busy nor answered");

  a_full_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe && result_o.table_full) |->
      (result_o.faces_held == bft_pkg::HeldW'(bft_pkg::TableDepth)))
    else $error("insert dropped while table has room");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bft_pkg::StScan) |-> (bft_pkg::CountBits'(idx_q) < count_q))
    else $error("scan index past fill count");
`endif

endmodule
